[hdl/mixed_node_flux_difference_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the mixed node flux difference block
// Checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIXED_NODE_FLUX_DIFFERENCE_ASSERT_SVH
`define MIXED_NODE_FLUX_DIFFERENCE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MNFD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MNFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MNFD_ASSERT_IMPLY(label, ante, cons, msg)

`define MNFD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/mnfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnfd_pkg
// Widths, constants and helper functions shared by the flux difference block.
// ----------------------------------------------------------------------------
package mnfd_pkg;

	// Sample and history widths.
	localparam int FLUX_W     = 32;
	localparam int PT_W       = 16;
	localparam int VAR_W      = 3;
	localparam int HIST_DEPTH = 3;
	localparam int HIST_W     = HIST_DEPTH * FLUX_W;

	// First point that produces a result.
	localparam logic [PT_W-1:0] EMIT_POINT = PT_W'(3);

	// Reset value of the step reciprocal, 1.0 in Q16.16.
	localparam logic [FLUX_W-1:0] INV_STEP_RESET = 32'h0001_0000;

	// Stencil sum and its magnitude.
	localparam int S_W      = 40;
	localparam int MAG_W    = 39;
	localparam int MAG_LO_W = 32;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;

	// Product widths of the two partial products and the full product.
	localparam int LO_PROD_W = MAG_LO_W + FLUX_W;
	localparam int HI_PROD_W = MAG_HI_W + FLUX_W;
	localparam int PROD_W    = MAG_W + FLUX_W + 1;

	// Rounding: add half of 30 * 2^16, then drop 17 bits and divide by 15.
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(983040);
	localparam int QUOT_SHIFT = 17;

	// Radix-16 long division by 15.
	localparam int DIGIT_W   = 4;
	localparam int DIV_W     = 56;
	localparam int DIV_STEPS = DIV_W / DIGIT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Final sum before saturation.
	localparam int SUM_W = DIV_W + 2;
	localparam logic signed [SUM_W-1:0] RHS_MAX = {{(SUM_W-FLUX_W+1){1'b0}}, {(FLUX_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] RHS_MIN = {{(SUM_W-FLUX_W+1){1'b1}}, {(FLUX_W-1){1'b0}}};

	// Quotient digit of v / 15 for v below 240, by reciprocal multiply.
	function automatic logic [DIGIT_W-1:0] div15_digit(input logic [2*DIGIT_W-1:0] v);
		logic [15:0] prod;
		prod = 16'(v) * 16'd137;
		return prod[14:11];
	endfunction

endpackage

[hdl/mnfd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnfd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mnfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/mnfd_scale.sv]
`timescale 1ns / 1ps
`include "mixed_node_flux_difference_assert.svh"
// ----------------------------------------------------------------------------
// mnfd_scale
// Multiplies the stencil magnitude by the step reciprocal in two partial
// products, then divides by 30 * 2^16 with rounding, one radix-16 digit a cycle.
// ----------------------------------------------------------------------------
module mnfd_scale import mnfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  mag,
	input  logic [FLUX_W-1:0] mult,
	output logic              done,
	output logic [DIV_W-1:0]  quot
);

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_HI,
		SC_DIV
	} sc_state_t;

	sc_state_t              st_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   done_q;
	logic [LO_PROD_W-1:0]   acc_q;
	logic [MAG_HI_W-1:0]    hi_q;
	logic [FLUX_W-1:0]      mult_q;
	logic [DIV_W-1:0]       div_q;
	logic [DIGIT_W-1:0]     rem_q;

	logic [LO_PROD_W-1:0]   lo_prod;
	logic [HI_PROD_W-1:0]   hi_prod;
	logic [PROD_W-1:0]      full_prod;
	logic [2*DIGIT_W-1:0]   dig_in;
	logic [DIGIT_W-1:0]     dig;
	logic [2*DIGIT_W-1:0]   dig_rem;

	// Low partial product, taken on start.
	assign lo_prod = LO_PROD_W'(mag[MAG_LO_W-1:0]) * LO_PROD_W'(mult);

	// High partial product joined with the low one and the rounding bias.
	assign hi_prod   = HI_PROD_W'(hi_q) * HI_PROD_W'(mult_q);
	assign full_prod = PROD_W'(acc_q) + {hi_prod, {MAG_LO_W{1'b0}}} + ROUND_BIAS;

	// One quotient digit of the division by 15.
	assign dig_in  = {rem_q, div_q[DIV_W-1 -: DIGIT_W]};
	assign dig     = div15_digit(dig_in);
	assign dig_rem = dig_in - (2*DIGIT_W)'(dig) * (2*DIGIT_W)'(15);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				SC_IDLE: begin
					if (start) begin
						st_q <= SC_HI;
					end
				end
				SC_HI: begin
					cnt_q <= '0;
					st_q  <= SC_DIV;
				end
				SC_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						done_q <= 1'b1;
						st_q   <= SC_IDLE;
					end
				end
				default: begin
					st_q <= SC_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			SC_IDLE: begin
				if (start) begin
					acc_q  <= lo_prod;
					hi_q   <= mag[MAG_W-1:MAG_LO_W];
					mult_q <= mult;
				end
			end
			SC_HI: begin
				div_q <= DIV_W'(full_prod[PROD_W-1:QUOT_SHIFT]);
				rem_q <= '0;
			end
			SC_DIV: begin
				div_q <= {div_q[DIV_W-DIGIT_W-1:0], dig};
				rem_q <= dig_rem[DIGIT_W-1:0];
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign done = done_q;
	assign quot = div_q;

	`MNFD_ASSERT_IMPLY(a_start_when_idle, start, st_q == SC_IDLE, "scale unit started while busy")
	`MNFD_ASSERT_IMPLY(a_done_after_div, done_q, $past(st_q) == SC_DIV, "done without a division step")
	`MNFD_ASSERT_NEXT(a_hi_to_div, st_q == SC_HI, st_q == SC_DIV, "multiply step not followed by division")

endmodule

[hdl/mixed_node_flux_difference.sv]
`timescale 1ns / 1ps
`include "mixed_node_flux_difference_assert.svh"
// A beat goes through the read, magnitude, scale and finish states to the
// output register, held in finish by a result-side stall; no new beat is taken
// before it leaves. Early points end after the read; out-of-range variables are
// dropped on accept. Scale: two-step multiply, 14-step radix-16 divide.
// Reset clears control state and loads inv_step with 1.0; the history memories
// keep whatever they hold and are defined only once written.
// ----------------------------------------------------------------------------
// mixed_node_flux_difference
// Per-variable flux history in two memories, read-modify-write per beat, and
// a mixed half-point / node sixth-order difference added to the right side.
// ----------------------------------------------------------------------------
module mixed_node_flux_difference import mnfd_pkg::*; #(
	parameter int MAX_VARS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [FLUX_W-1:0]        cfg_wr_data,
	// sample channel
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic [PT_W-1:0]          point_index,
	input  logic [VAR_W-1:0]         var_index,
	input  logic signed [FLUX_W-1:0] half_flux,
	input  logic signed [FLUX_W-1:0] node_flux,
	input  logic signed [FLUX_W-1:0] rhs_in,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [PT_W-1:0]          out_point,
	output logic [VAR_W-1:0]         out_var,
	output logic signed [FLUX_W-1:0] rhs_out,
	output logic                     saturated
);

	localparam int ADDR_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ABS,
		ST_SCALE,
		ST_FINISH
	} state_t;

	state_t                   state_q;
	logic                     start_q;
	logic                     result_valid_q;
	logic [PT_W-1:0]          out_point_q;
	logic [VAR_W-1:0]         out_var_q;
	logic signed [FLUX_W-1:0] rhs_out_q;
	logic                     saturated_q;
	logic [FLUX_W-1:0]        inv_step_q;

	// Captured beat and intermediate values.
	logic [PT_W-1:0]          pt_q;
	logic [VAR_W-1:0]         var_q;
	logic [FLUX_W-1:0]        half_q;
	logic [FLUX_W-1:0]        node_q;
	logic signed [FLUX_W-1:0] rhs_q;
	logic                     emit_q;
	logic signed [S_W-1:0]    s_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;

	logic                     sample_acc;
	logic                     var_ok;
	logic                     ram_re;
	logic                     ram_we;
	logic [ADDR_W-1:0]        raddr;
	logic [ADDR_W-1:0]        waddr;
	logic [HIST_W-1:0]        half_rd;
	logic [HIST_W-1:0]        node_rd;
	logic [HIST_W-1:0]        half_wr;
	logic [HIST_W-1:0]        node_wr;

	logic signed [FLUX_W-1:0] h0, h1, h2, h3, n1, n3;
	logic signed [S_W-1:0]    dh12, dn13, dh03, s_next;
	logic [S_W-1:0]           s_abs;

	logic                     scale_done;
	logic [DIV_W-1:0]         scale_quot;
	logic signed [SUM_W-1:0]  q_ext, inc, total;
	logic                     sat_hi, sat_lo;
	logic signed [FLUX_W-1:0] rhs_sat;
	logic                     out_load;

	// Handshake on the sample side; one beat is worked at a time.
	assign sample_stall = (state_q != ST_IDLE);
	assign sample_acc   = sample_valid && !sample_stall;
	assign var_ok       = ({{(32-VAR_W){1'b0}}, var_index} < 32'(MAX_VARS));

	// History read on accept, write back in the following cycle.
	assign ram_re  = sample_acc && var_ok;
	assign raddr   = ADDR_W'(var_index);
	assign ram_we  = (state_q == ST_READ);
	assign waddr   = ADDR_W'(var_q);
	assign half_wr = {half_rd[HIST_W-FLUX_W-1:0], half_q};
	assign node_wr = {node_rd[HIST_W-FLUX_W-1:0], node_q};

	mnfd_ram #(
		.WIDTH (HIST_W),
		.DEPTH (MAX_VARS)
	) u_half_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (half_wr),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (half_rd)
	);

	mnfd_ram #(
		.WIDTH (HIST_W),
		.DEPTH (MAX_VARS)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (node_wr),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (node_rd)
	);

	// Stencil sum: 45*(h1-h2) - 9*(n1-n3) + (h0-h3), newest entry in the low word.
	assign h0 = half_q;
	assign h1 = half_rd[FLUX_W-1:0];
	assign h2 = half_rd[2*FLUX_W-1:FLUX_W];
	assign h3 = half_rd[HIST_W-1:HIST_W-FLUX_W];
	assign n1 = node_rd[FLUX_W-1:0];
	assign n3 = node_rd[HIST_W-1:HIST_W-FLUX_W];

	assign dh12   = S_W'(h1) - S_W'(h2);
	assign dn13   = S_W'(n1) - S_W'(n3);
	assign dh03   = S_W'(h0) - S_W'(h3);
	assign s_next = dh12 * S_W'(45) - dn13 * S_W'(9) + dh03;

	// Magnitude of the stencil sum.
	assign s_abs = s_q[S_W-1] ? -s_q : s_q;

	mnfd_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mag    (mag_q),
		.mult   (inv_step_q),
		.done   (scale_done),
		.quot   (scale_quot)
	);

	// Signed increment added to the incoming right side, then clipped.
	assign q_ext   = {{(SUM_W-DIV_W){1'b0}}, scale_quot};
	assign inc     = neg_q ? -q_ext : q_ext;
	assign total   = SUM_W'(rhs_q) + inc;
	assign sat_hi  = (total > RHS_MAX);
	assign sat_lo  = (total < RHS_MIN);
	assign rhs_sat = sat_hi ? RHS_MAX[FLUX_W-1:0] :
	                 sat_lo ? RHS_MIN[FLUX_W-1:0] : total[FLUX_W-1:0];

	// The output register takes a new result once the old beat has left.
	assign out_load = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_step_q <= INV_STEP_RESET;
		end else if (cfg_wr_en) begin
			inv_step_q <= cfg_wr_data;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			start_q        <= 1'b0;
			result_valid_q <= 1'b0;
			out_point_q    <= '0;
			out_var_q      <= '0;
			rhs_out_q      <= '0;
			saturated_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_load) begin
				result_valid_q <= 1'b1;
				out_point_q    <= pt_q - EMIT_POINT;
				out_var_q      <= var_q;
				rhs_out_q      <= rhs_sat;
				saturated_q    <= sat_hi || sat_lo;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ram_re) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= emit_q ? ST_ABS : ST_IDLE;
				end
				ST_ABS: begin
					start_q <= 1'b1;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (scale_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Beat capture and intermediate datapath registers.
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			pt_q   <= point_index;
			var_q  <= var_index;
			half_q <= half_flux;
			node_q <= node_flux;
			rhs_q  <= rhs_in;
			emit_q <= (point_index >= EMIT_POINT);
		end
		if (state_q == ST_READ) begin
			s_q <= s_next;
		end
		if (state_q == ST_ABS) begin
			mag_q <= s_abs[MAG_W-1:0];
			neg_q <= s_q[S_W-1];
		end
	end

	assign result_valid = result_valid_q;
	assign out_point    = out_point_q;
	assign out_var      = out_var_q;
	assign rhs_out      = rhs_out_q;
	assign saturated    = saturated_q;

	`MNFD_ASSERT_IMPLY(a_no_rw_overlap, ram_we, !ram_re, "history read overlaps write-back")
	`MNFD_ASSERT_IMPLY(a_done_in_scale, scale_done, state_q == ST_SCALE, "unexpected scale done")
	`MNFD_ASSERT_NEXT(a_done_to_finish, scale_done, state_q == ST_FINISH, "scale result not taken")
	`MNFD_ASSERT_IMPLY(a_result_from_finish, $rose(result_valid), $past(state_q) == ST_FINISH, "result without finish")

endmodule
